// ===== hdl/rsdw_pkg.sv =====
package rsdw_pkg;

    // Sequence window geometry
    localparam int unsigned WINDOW_BITS = 4096;
    localparam int unsigned ROW_BITS    = 64;
    localparam int unsigned ROWS        = WINDOW_BITS / ROW_BITS;
    localparam int unsigned WIN_AW      = $clog2(WINDOW_BITS);
    localparam int unsigned ROW_AW      = $clog2(ROWS);
    localparam int unsigned OFF_W       = $clog2(ROW_BITS);
    localparam int unsigned CNT_W       = OFF_W + 1;

    localparam int unsigned SEQ_W       = 16;
    localparam int unsigned LEN_W       = 11;
    localparam int unsigned SID_W       = 32;
    localparam int unsigned PORT_W      = 4;
    localparam int unsigned GAP_W       = 15;

    localparam logic [LEN_W-1:0] MIN_LENGTH = LEN_W'(12);

    typedef logic [ROW_AW-1:0]   t_row_addr;
    typedef logic [ROW_BITS-1:0] t_row;

    // Bitmap memory access, one per cycle
    typedef struct packed {
        t_row_addr rd_addr;
        logic      wr_en;
        t_row_addr wr_addr;
        t_row      wr_data;
        logic      clr_all;
    } t_bm_req;

endpackage

// ===== hdl/rsdw_bitmap.sv =====
module rsdw_bitmap (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  rsdw_pkg::t_bm_req i_req,
    output rsdw_pkg::t_row   o_rd_data
);

    rsdw_pkg::t_row               r_mem [rsdw_pkg::ROWS];
    logic [rsdw_pkg::ROWS-1:0]    r_row_vld;
    rsdw_pkg::t_row               r_rd_data;
    logic                         r_rd_vld;

    // storage, no reset
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        r_rd_data <= r_mem[i_req.rd_addr];
    end

    // row flags: an invalid row reads as all zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            r_rd_vld <= r_row_vld[i_req.rd_addr];
            if (i_req.clr_all) begin
                r_row_vld <= '0;
            end else if (i_req.wr_en) begin
                r_row_vld[i_req.wr_addr] <= 1'b1;
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

// ===== hdl/rtp_sequence_dedup_window.sv =====
// Channel   Direction  Handshake                 Payload
// request   in         i_in_valid / o_in_stall   i_packet_length, i_sequence_number,
//                                                i_stream_id, i_source_port
// verdict   out        o_out_valid / i_out_stall o_ignored, o_forward, o_duplicate,
//                                                o_stream_restart, o_gap_size, o_late,
//                                                o_port_echo
//
// One request at a time. A forward slide of less than a window sweeps each bitmap row it
// covers in turn (read, then masked write through the single bitmap port). Reset is
// synchronous; the bitmap's row flags clear at once, so no clearing pass. A new request is
// taken while the previous verdict still waits on i_out_stall.
module rtp_sequence_dedup_window (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [rsdw_pkg::LEN_W-1:0]   i_packet_length,
    input  logic [rsdw_pkg::SEQ_W-1:0]   i_sequence_number,
    input  logic [rsdw_pkg::SID_W-1:0]   i_stream_id,
    input  logic [rsdw_pkg::PORT_W-1:0]  i_source_port,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_ignored,
    output logic                         o_forward,
    output logic                         o_duplicate,
    output logic                         o_stream_restart,
    output logic [rsdw_pkg::GAP_W-1:0]   o_gap_size,
    output logic                         o_late,
    output logic [rsdw_pkg::PORT_W-1:0]  o_port_echo
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_SWEEP_RD,
        S_SWEEP_WR,
        S_LOOKUP,
        S_MARK,
        S_RESULT
    } t_state;

    localparam int unsigned SEQ_W  = rsdw_pkg::SEQ_W;
    localparam int unsigned WIN_AW = rsdw_pkg::WIN_AW;
    localparam int unsigned OFF_W  = rsdw_pkg::OFF_W;
    localparam int unsigned CNT_W  = rsdw_pkg::CNT_W;

    localparam logic [SEQ_W-1:0] WIN_SIZE = SEQ_W'(rsdw_pkg::WINDOW_BITS);
    localparam logic [SEQ_W-1:0] WIN_LAST = SEQ_W'(rsdw_pkg::WINDOW_BITS - 1);
    localparam logic [CNT_W-1:0] ROW_SIZE = CNT_W'(rsdw_pkg::ROW_BITS);

    t_state                        r_state;

    // latched request
    logic [SEQ_W-1:0]              r_seq;
    logic [rsdw_pkg::PORT_W-1:0]   r_port;

    // filter state
    logic [SEQ_W-1:0]              r_base;
    logic [rsdw_pkg::SID_W-1:0]    r_stream;
    logic [SEQ_W-1:0]              r_last;
    logic                          r_last_vld;

    // slide sweep: next bit position to clear and bits still to clear
    logic [WIN_AW-1:0]             r_pos;
    logic [WIN_AW-1:0]             r_rem;

    // verdict under construction
    logic                          r_ign, r_fwd, r_dup, r_rst, r_late;
    logic [rsdw_pkg::GAP_W-1:0]    r_gap;

    // output register
    logic                          r_out_vld;
    logic                          r_o_ign, r_o_fwd, r_o_dup, r_o_rst, r_o_late;
    logic [rsdw_pkg::GAP_W-1:0]    r_o_gap;
    logic [rsdw_pkg::PORT_W-1:0]   r_o_port;

    rsdw_pkg::t_bm_req             bm_req;
    rsdw_pkg::t_row                bm_rd;

    logic                          in_acc;
    logic                          restart;
    logic [SEQ_W-1:0]              diff;
    logic [SEQ_W-1:0]              shift;
    logic                          ahead;
    logic                          far_ahead;
    logic [OFF_W-1:0]              sw_off;
    logic [CNT_W-1:0]              sw_room;
    logic [CNT_W-1:0]              sw_n;
    logic [CNT_W-1:0]              sw_end;
    rsdw_pkg::t_row                sw_mask;
    logic                          sw_last;
    logic                          seen;
    logic [SEQ_W-1:0]              gap_d;
    logic                          out_free;

    rsdw_bitmap u_bitmap (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (bm_req),
        .o_rd_data (bm_rd)
    );

    assign in_acc   = i_in_valid && !o_in_stall;
    assign restart  = (i_packet_length >= rsdw_pkg::MIN_LENGTH) && (i_stream_id != r_stream);
    assign out_free = !r_out_vld || !i_out_stall;

    // position of the sequence against the window start
    assign diff      = r_seq - r_base;
    assign ahead     = !diff[SEQ_W-1] && (diff >= WIN_SIZE);
    assign shift     = diff - WIN_LAST;
    assign far_ahead = shift >= WIN_SIZE;

    // one row segment of the slide clear
    assign sw_off  = r_pos[OFF_W-1:0];
    assign sw_room = ROW_SIZE - CNT_W'(sw_off);
    assign sw_n    = (r_rem < WIN_AW'(sw_room)) ? CNT_W'(r_rem) : sw_room;
    assign sw_end  = CNT_W'(sw_off) + sw_n;
    assign sw_last = r_rem == WIN_AW'(sw_n);

    always_comb begin
        for (int i = 0; i < rsdw_pkg::ROW_BITS; i++) begin
            sw_mask[i] = (CNT_W'(i) >= CNT_W'(sw_off)) && (CNT_W'(i) < sw_end);
        end
    end

    assign seen  = bm_rd[r_seq[OFF_W-1:0]];
    assign gap_d = r_seq - (r_last + SEQ_W'(1));

    // bitmap port
    always_comb begin
        bm_req         = '0;
        bm_req.rd_addr = (r_state == S_SWEEP_RD) ? r_pos[WIN_AW-1:OFF_W]
                                                 : r_seq[WIN_AW-1:OFF_W];
        case (r_state)
            S_IDLE: begin
                bm_req.clr_all = in_acc && restart;
            end
            S_EVAL: begin
                bm_req.clr_all = ahead && far_ahead;
            end
            S_SWEEP_WR: begin
                bm_req.wr_en   = 1'b1;
                bm_req.wr_addr = r_pos[WIN_AW-1:OFF_W];
                bm_req.wr_data = bm_rd & ~sw_mask;
            end
            S_MARK: begin
                bm_req.wr_en   = !seen;
                bm_req.wr_addr = r_seq[WIN_AW-1:OFF_W];
                bm_req.wr_data = bm_rd | (rsdw_pkg::t_row'(1) << r_seq[OFF_W-1:0]);
            end
            default: begin
                bm_req.wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_base     <= '0;
            r_stream   <= '0;
            r_last     <= '0;
            r_last_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            // verdict register: load a finished verdict, else drop a taken one
            if (r_state == S_RESULT && out_free) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_seq  <= i_sequence_number;
                        r_port <= i_source_port;
                        r_fwd  <= 1'b0;
                        r_dup  <= 1'b0;
                        r_gap  <= '0;
                        r_late <= 1'b0;
                        r_ign  <= i_packet_length < rsdw_pkg::MIN_LENGTH;
                        r_rst  <= restart;
                        if (restart) begin
                            r_stream   <= i_stream_id;
                            r_base     <= i_sequence_number;
                            r_last_vld <= 1'b0;
                        end
                        r_state <= (i_packet_length < rsdw_pkg::MIN_LENGTH) ? S_RESULT : S_EVAL;
                    end
                end
                S_EVAL: begin
                    if (diff[SEQ_W-1]) begin
                        // older than the window
                        r_dup   <= 1'b1;
                        r_state <= S_RESULT;
                    end else if (ahead) begin
                        r_base <= r_base + shift;
                        r_pos  <= r_base[WIN_AW-1:0];
                        r_rem  <= shift[WIN_AW-1:0];
                        r_state <= far_ahead ? S_LOOKUP : S_SWEEP_RD;
                    end else begin
                        r_state <= S_LOOKUP;
                    end
                end
                S_SWEEP_RD: begin
                    r_state <= S_SWEEP_WR;
                end
                S_SWEEP_WR: begin
                    r_pos   <= r_pos + WIN_AW'(sw_n);
                    r_rem   <= r_rem - WIN_AW'(sw_n);
                    r_state <= sw_last ? S_LOOKUP : S_SWEEP_RD;
                end
                S_LOOKUP: begin
                    r_state <= S_MARK;
                end
                S_MARK: begin
                    if (seen) begin
                        r_dup <= 1'b1;
                    end else begin
                        r_fwd <= 1'b1;
                        if (r_last_vld) begin
                            r_late <= gap_d[SEQ_W-1];
                            r_gap  <= gap_d[SEQ_W-1] ? '0 : gap_d[rsdw_pkg::GAP_W-1:0];
                        end
                        r_last     <= r_seq;
                        r_last_vld <= 1'b1;
                    end
                    r_state <= S_RESULT;
                end
                S_RESULT: begin
                    if (out_free) begin
                        r_o_ign   <= r_ign;
                        r_o_fwd   <= r_fwd;
                        r_o_dup   <= r_dup;
                        r_o_rst   <= r_ign ? 1'b0 : r_rst;
                        r_o_gap   <= r_gap;
                        r_o_late  <= r_late;
                        r_o_port  <= r_port;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall       = r_state != S_IDLE;
    assign o_out_valid      = r_out_vld;
    assign o_ignored        = r_o_ign;
    assign o_forward        = r_o_fwd;
    assign o_duplicate      = r_o_dup;
    assign o_stream_restart = r_o_rst;
    assign o_gap_size       = r_o_gap;
    assign o_late           = r_o_late;
    assign o_port_echo      = r_o_port;

endmodule
